>>> rtl/relay_feedback_pid_autotuner_core_defines.svh
// assertion macros of the autotuner rtl
`ifndef RELAY_FEEDBACK_PID_AUTOTUNER_CORE_DEFINES_SVH
`define RELAY_FEEDBACK_PID_AUTOTUNER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFPA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RFPA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rfpa_pkg.sv
// shared types, codes and constants of the relay feedback autotuner
package rfpa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int HIST_DEPTH  = 10;
   localparam int GAIN_W      = 31;
   localparam int NUM_W       = 50;
   localparam int DEN_W       = 51;
   localparam int PA_W        = 35;
   localparam int PROD_W      = 31;
   localparam int DIV_STEPS   = 33;
   localparam int CNT_W       = 6;

   localparam logic [2:0] PH_INIT     = 3'd0;
   localparam logic [2:0] PH_PREHEAT  = 3'd1;
   localparam logic [2:0] PH_COAST    = 3'd2;
   localparam logic [2:0] PH_PRESHAKE = 3'd3;
   localparam logic [2:0] PH_OSC      = 3'd4;
   localparam logic [2:0] PH_ANALYSE  = 3'd5;
   localparam logic [2:0] PH_DONE     = 3'd6;

   localparam logic [1:0] EDGE_NONE  = 2'd0;
   localparam logic [1:0] EDGE_LOW   = 2'd1;
   localparam logic [1:0] EDGE_HIGH  = 2'd2;

   localparam logic [1:0] G_P = 2'd0;
   localparam logic [1:0] G_I = 2'd1;
   localparam logic [1:0] G_D = 2'd2;

   localparam logic [7:0] REG_RELAY  = 8'd0;
   localparam logic [7:0] REG_RATE   = 8'd1;
   localparam logic [7:0] REG_VECTOR = 8'd2;
   localparam logic [7:0] REG_MARGIN = 8'd3;

   localparam logic [14:0] RELAY_RESET = 15'd5000;
   localparam logic [15:0] RATE_RESET  = 16'd200;

   localparam logic [18:0] PI_NUM = 19'd314159;
   localparam logic [18:0] K_P    = 19'd240000;
   localparam logic [18:0] K_I    = 19'd480000;
   localparam logic [18:0] K_D    = 19'd30000;

   localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

   typedef struct packed {
      logic       take;
      logic       work;
      logic       mul;
      logic       load;
      logic       check;
      logic       iter;
      logic       store;
      logic       emit;
      logic [1:0] gsel;
   } cmd_type;

   typedef struct packed {
      logic analyse_go;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/rfpa_ctrl.sv
// controller state machine of the autotuner
`include "relay_feedback_pid_autotuner_core_defines.svh"

module rfpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rfpa_pkg::status_type status,
   output rfpa_pkg::cmd_type    cmd
);
   import rfpa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WORK  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_ITER  = 3'd5;
   localparam logic [2:0] S_STORE = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       gsel_ff, gsel_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      gsel_in  = gsel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_WORK;
         end
         S_WORK: begin
            state_in = status.analyse_go ? S_MUL : S_EMIT;
         end
         S_MUL: begin
            state_in = S_LOAD;
            gsel_in  = G_P;
         end
         S_LOAD:  state_in = S_CHECK;
         S_CHECK: begin
            state_in = S_ITER;
            cnt_in   = '0;
         end
         S_ITER: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_STORE;
            else cnt_in = cnt_ff + CNT_W'(1);
         end
         S_STORE: begin
            if (gsel_ff == G_D) begin
               state_in = S_EMIT;
            end else begin
               gsel_in  = gsel_ff + 2'd1;
               state_in = S_LOAD;
            end
         end
         S_EMIT: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         gsel_ff  <= G_P;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         gsel_ff  <= gsel_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.take  = (state_ff == S_IDLE) && req_valid;
      cmd.work  = (state_ff == S_WORK);
      cmd.mul   = (state_ff == S_MUL);
      cmd.load  = (state_ff == S_LOAD);
      cmd.check = (state_ff == S_CHECK);
      cmd.iter  = (state_ff == S_ITER);
      cmd.store = (state_ff == S_STORE);
      cmd.emit  = (state_ff == S_EMIT) && status.rsp_free;
      cmd.gsel  = gsel_ff;
   end

   `RFPA_ASSERT_NXT(a_take_work, cmd.take, state_ff == S_WORK, "accepted request not worked")
   `RFPA_ASSERT_IMP(a_emit_free, cmd.emit, status.rsp_free, "result emitted over a pending one")
   `RFPA_ASSERT_IMP(a_cnt_range, state_ff == S_ITER, cnt_ff < CNT_W'(DIV_STEPS), "step count overrun")
   `RFPA_ASSERT_IMP(a_gsel_range, state_ff == S_LOAD, gsel_ff != 2'd3, "bad gain select")

endmodule

>>> rtl/rfpa_dp.sv
// datapath of the autotuner: settings, tuning state, divider, result register
module rfpa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rfpa_pkg::cmd_type                   cmd,
   output rfpa_pkg::status_type                status,
   input  logic signed [rfpa_pkg::SAMPLE_W-1:0] req_target,
   input  logic signed [rfpa_pkg::SAMPLE_W-1:0] req_measured,
   input  logic signed [rfpa_pkg::SAMPLE_W-1:0] req_pid_drive,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rfpa_pkg::SAMPLE_W-1:0] rsp_drive,
   output logic [2:0]                          rsp_phase,
   output logic                                rsp_done_res,
   output logic                                rsp_zero_amplitude,
   output logic [rfpa_pkg::GAIN_W-1:0]         rsp_gain_p,
   output logic [rfpa_pkg::GAIN_W-1:0]         rsp_gain_i,
   output logic [rfpa_pkg::GAIN_W-1:0]         rsp_gain_d,
   input  logic                                csr_valid,
   input  logic [7:0]                          csr_index,
   input  logic [15:0]                         csr_data
);
   import rfpa_pkg::*;

   logic [14:0]        relay_ff;
   logic [15:0]        rate_ff;
   logic               vector_ff;
   logic signed [15:0] margin_ff;

   logic signed [SAMPLE_W-1:0] tgt_ff, mea_ff, pid_ff;

   logic [2:0]                 phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] hist_ff [HIST_DEPTH];
   logic [1:0]                 edge_ff, edge_in;
   logic [15:0]                tick_ff, tick_in;
   logic [15:0]                ttime_ff, ttime_in, ptime_ff, ptime_in;
   logic signed [SAMPLE_W-1:0] tval_ff, tval_in, pval_ff, pval_in;
   logic signed [SAMPLE_W-1:0] held_ff, held_in;
   logic                       zero_ff;
   logic [GAIN_W-1:0]          gain_ff [3];

   logic signed [16:0] heat_sum, tgt_x;
   logic signed [SAMPLE_W-1:0] relay_pos;
   logic        below, falling;
   logic [16:0] amp_diff;
   logic        amp_zero;
   logic [15:0] tick_inc;

   // divider
   logic [15:0]       amp_ff, per_ff;
   logic [PA_W-1:0]   pa_ff;
   logic [PROD_W-1:0] rr_ff, rp_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DIV_STEPS-1:0] nsh_ff, q_ff;
   logic              sat_ff;
   logic [DEN_W:0]    rem_sh;
   logic              fits;
   logic [DIV_STEPS:0] q_round;
   logic [GAIN_W-1:0] gain_res;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff  <= RELAY_RESET;
         rate_ff   <= RATE_RESET;
         vector_ff <= 1'b0;
         margin_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RELAY:  relay_ff  <= csr_data[14:0];
            REG_RATE:   rate_ff   <= csr_data;
            REG_VECTOR: vector_ff <= csr_data[0];
            REG_MARGIN: margin_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         tgt_ff <= req_target;
         mea_ff <= req_measured;
         pid_ff <= req_pid_drive;
      end
   end

   assign heat_sum  = {mea_ff[SAMPLE_W-1], mea_ff} + {margin_ff[15], margin_ff};
   assign tgt_x     = {tgt_ff[SAMPLE_W-1], tgt_ff};
   assign relay_pos = {1'b0, relay_ff};
   assign below     = mea_ff < tgt_ff;
   assign falling   = mea_ff < hist_ff[HIST_DEPTH-2];
   assign tick_inc  = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
   assign amp_diff  = {pval_ff[SAMPLE_W-1], pval_ff} - {tval_ff[SAMPLE_W-1], tval_ff};
   assign amp_zero  = amp_diff[16] || (amp_diff == 17'd0);

   // one control tick
   always_comb begin
      phase_in = phase_ff;
      edge_in  = edge_ff;
      tick_in  = tick_ff;
      ttime_in = ttime_ff;
      tval_in  = tval_ff;
      ptime_in = ptime_ff;
      pval_in  = pval_ff;
      held_in  = held_ff;
      case (phase_ff)
         PH_INIT: begin
            tick_in  = '0;
            ttime_in = '0;
            ptime_in = '0;
            tval_in  = '0;
            pval_in  = '0;
            phase_in = PH_PREHEAT;
         end
         PH_PREHEAT: begin
            if (heat_sum < tgt_x && !vector_ff) begin
               held_in = pid_ff;
            end else begin
               held_in  = '0;
               phase_in = PH_COAST;
            end
         end
         PH_COAST: begin
            if (falling) phase_in = PH_PRESHAKE;
         end
         PH_PRESHAKE: begin
            if (below) begin
               held_in = relay_pos;
               edge_in = EDGE_HIGH;
            end else begin
               held_in = -relay_pos;
               if (edge_ff == EDGE_NONE) begin
                  edge_in = EDGE_LOW;
               end else if (edge_ff == EDGE_HIGH) begin
                  edge_in  = EDGE_NONE;
                  tick_in  = '0;
                  phase_in = PH_OSC;
               end
            end
         end
         PH_OSC: begin
            tick_in = tick_inc;
            if (below) begin
               held_in = relay_pos;
               if (edge_ff == EDGE_NONE) begin
                  edge_in  = EDGE_LOW;
                  ttime_in = tick_inc;
                  tval_in  = mea_ff;
               end else if (edge_ff == EDGE_LOW && mea_ff < tval_ff) begin
                  ttime_in = tick_inc;
                  tval_in  = mea_ff;
               end
            end else begin
               held_in = -relay_pos;
               if (edge_ff == EDGE_LOW) begin
                  edge_in  = EDGE_HIGH;
                  ptime_in = tick_inc;
                  pval_in  = mea_ff;
               end else if (edge_ff == EDGE_HIGH && mea_ff > pval_ff) begin
                  ptime_in = tick_inc;
                  pval_in  = mea_ff;
               end
               if (edge_ff == EDGE_LOW || edge_ff == EDGE_HIGH) begin
                  if (falling) begin
                     phase_in = PH_ANALYSE;
                     held_in  = '0;
                  end
               end
            end
         end
         default: phase_in = PH_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INIT;
         edge_ff  <= EDGE_NONE;
         tick_ff  <= '0;
         ttime_ff <= '0;
         ptime_ff <= '0;
         tval_ff  <= '0;
         pval_ff  <= '0;
         held_ff  <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) hist_ff[i] <= '0;
      end else if (cmd.work) begin
         phase_ff <= phase_in;
         edge_ff  <= edge_in;
         tick_ff  <= tick_in;
         ttime_ff <= ttime_in;
         ptime_ff <= ptime_in;
         tval_ff  <= tval_in;
         pval_ff  <= pval_in;
         held_ff  <= held_in;
         if (phase_ff == PH_INIT) begin
            for (int i = 0; i < HIST_DEPTH; i++) hist_ff[i] <= '0;
         end else if (phase_ff != PH_DONE) begin
            hist_ff[0] <= mea_ff;
            for (int i = 1; i < HIST_DEPTH; i++) hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   // gains and zero flag
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= 1'b0;
         for (int i = 0; i < 3; i++) gain_ff[i] <= '0;
      end else if (cmd.work && phase_ff == PH_INIT) begin
         zero_ff <= 1'b0;
         for (int i = 0; i < 3; i++) gain_ff[i] <= '0;
      end else if (cmd.work && phase_ff == PH_ANALYSE) begin
         zero_ff <= amp_zero;
         if (amp_zero) begin
            for (int i = 0; i < 3; i++) gain_ff[i] <= GAIN_MAX;
         end
      end else if (cmd.store) begin
         gain_ff[cmd.gsel] <= gain_res;
      end
   end

   assign status.analyse_go = (phase_ff == PH_ANALYSE) && !amp_zero;

   // products, then restoring division of num * 2^17 by den
   assign rem_sh  = {rem_ff, nsh_ff[DIV_STEPS-1]};
   assign fits    = rem_sh >= {1'b0, den_ff};
   assign q_round = {1'b0, q_ff} + (DIV_STEPS+1)'(1);
   assign gain_res = (sat_ff || q_ff >= {1'b0, {(DIV_STEPS-1){1'b1}}}) ?
                     GAIN_MAX : q_round[GAIN_W:1];

   always_ff @(posedge clock) begin
      if (cmd.work) begin
         amp_ff <= amp_diff[15:0];
         per_ff <= ptime_ff - ttime_ff;
      end
      if (cmd.mul) begin
         pa_ff <= PA_W'(PI_NUM) * PA_W'(amp_ff);
         rr_ff <= PROD_W'(relay_ff) * PROD_W'(rate_ff);
         rp_ff <= PROD_W'(relay_ff) * PROD_W'(per_ff);
      end
      if (cmd.load) begin
         case (cmd.gsel)
            G_P: begin
               num_ff <= NUM_W'(K_P) * NUM_W'(relay_ff);
               den_ff <= DEN_W'(pa_ff);
            end
            G_I: begin
               num_ff <= NUM_W'(K_I) * NUM_W'(rr_ff);
               den_ff <= DEN_W'(pa_ff) * DEN_W'(per_ff);
            end
            default: begin
               num_ff <= NUM_W'(K_D) * NUM_W'(rp_ff);
               den_ff <= DEN_W'(pa_ff) * DEN_W'(rate_ff);
            end
         endcase
      end
      if (cmd.check) begin
         sat_ff <= {17'd0, num_ff} >= {den_ff, 16'd0};
         rem_ff <= DEN_W'(num_ff[NUM_W-1:16]);
         nsh_ff <= {num_ff[15:0], 17'd0};
         q_ff   <= '0;
      end
      if (cmd.iter) begin
         rem_ff <= fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         nsh_ff <= {nsh_ff[DIV_STEPS-2:0], 1'b0};
         q_ff   <= {q_ff[DIV_STEPS-2:0], fits};
      end
   end

   // result register
   logic done_now;
   assign done_now = (phase_ff == PH_DONE);
   assign status.rsp_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_drive          <= done_now ? pid_ff : held_ff;
         rsp_phase          <= phase_ff;
         rsp_done_res       <= done_now;
         rsp_zero_amplitude <= done_now && zero_ff;
         rsp_gain_p         <= done_now ? gain_ff[G_P] : '0;
         rsp_gain_i         <= done_now ? gain_ff[G_I] : '0;
         rsp_gain_d         <= done_now ? gain_ff[G_D] : '0;
      end
   end

endmodule

>>> rtl/relay_feedback_pid_autotuner_core.sv
// top level of the relay feedback pid autotuner
// usage
//   one request per control tick on req_*: target, measured and pid_drive
//   one result per request on rsp_*: drive, phase, done flag, zero-amplitude
//   flag and the three q16.16 gains (zero until the done phase)
//   settings are written on csr_* (index 0 relay amplitude, 1 sample rate,
//   2 vector mode, 3 preheat margin); csr_ready is always high, other
//   indexes are dropped; write only while no request is in flight
// timing
//   ordinary tick: rsp_valid 2 cycles after acceptance, 3 cycles per tick
//   analyse tick: rsp_valid 111 cycles after acceptance: one product step,
//   then per gain a load, an overflow check, 33 restoring divide steps and
//   a store, all on the one shared divider
//   req_ready is high only while no request is being worked
// reset
//   synchronous, active high: settings return to their defaults, the
//   tuner goes to the init phase and the result register empties
// stalls
//   a finished result waits in the output register; a further request is
//   accepted meanwhile and its result holds until the first is taken
module relay_feedback_pid_autotuner_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rfpa_pkg::SAMPLE_W-1:0] req_target,
   input  logic signed [rfpa_pkg::SAMPLE_W-1:0] req_measured,
   input  logic signed [rfpa_pkg::SAMPLE_W-1:0] req_pid_drive,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rfpa_pkg::SAMPLE_W-1:0] rsp_drive,
   output logic [2:0]                          rsp_phase,
   output logic                                rsp_done_res,
   output logic                                rsp_zero_amplitude,
   output logic [rfpa_pkg::GAIN_W-1:0]         rsp_gain_p,
   output logic [rfpa_pkg::GAIN_W-1:0]         rsp_gain_i,
   output logic [rfpa_pkg::GAIN_W-1:0]         rsp_gain_d,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [7:0]                          csr_index,
   input  logic [15:0]                         csr_data
);
   import rfpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // settings writes never stall
   assign csr_ready = 1'b1;

   // sequencer: accept, tick update, divider steps, emit
   rfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // tuning state, gain divider and result register
   rfpa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_target         (req_target),
      .req_measured       (req_measured),
      .req_pid_drive      (req_pid_drive),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive          (rsp_drive),
      .rsp_phase          (rsp_phase),
      .rsp_done_res       (rsp_done_res),
      .rsp_zero_amplitude (rsp_zero_amplitude),
      .rsp_gain_p         (rsp_gain_p),
      .rsp_gain_i         (rsp_gain_i),
      .rsp_gain_d         (rsp_gain_d),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule

>>> tb/testbench.sv
// self-checking testbench for the relay feedback pid autotuner core
module testbench;
   import rfpa_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [SAMPLE_W-1:0] measured;
      logic signed [SAMPLE_W-1:0] pid_drive;
   } tick_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] drive;
      logic [2:0]                 phase;
      logic                       done_res;
      logic                       zero_amp;
      logic [GAIN_W-1:0]          gain_p;
      logic [GAIN_W-1:0]          gain_i;
      logic [GAIN_W-1:0]          gain_d;
   } tune_rsp_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [SAMPLE_W-1:0] req_target, req_measured, req_pid_drive;
   logic rsp_valid, rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_drive;
   logic [2:0] rsp_phase;
   logic rsp_done_res, rsp_zero_amplitude;
   logic [GAIN_W-1:0] rsp_gain_p, rsp_gain_i, rsp_gain_d;
   logic csr_valid, csr_ready;
   logic [7:0] csr_index;
   logic [15:0] csr_data;

   relay_feedback_pid_autotuner_core dut (.*);

   // tick requests waiting for the driver, expected responses in order
   tick_type     tick_queue[$];
   tune_rsp_type tune_rsp_queue[$];
   int        error_count = 0;
   int        req_gap = 0;
   bit        quiet = 0;

   // shadow of settings and tuner state
   int unsigned relay_r, rate_r, vector_r;
   int          margin_r;
   logic [2:0]  phase_q;
   int          hist[HIST_DEPTH];
   logic [1:0]  marker_q;
   int unsigned tick_q, trough_t, peak_t;
   int          trough_v, peak_v, held_drv;
   logic [GAIN_W-1:0] gains_q[3];
   bit          zero_q;

   function automatic logic [GAIN_W-1:0] q16_round(logic [127:0] num, logic [127:0] den);
      logic [127:0] q17;
      if (den == 0) return GAIN_MAX;
      q17 = (num << 17) / den;
      q17 = (q17 + 1) >> 1;
      return (q17 > GAIN_MAX) ? GAIN_MAX : q17[GAIN_W-1:0];
   endfunction

   task automatic compute_gains();
      int amp;
      logic [127:0] per, pa;
      amp = peak_v - trough_v;
      per = (peak_t - trough_t) & 32'hFFFF;
      if (amp <= 0) begin
         zero_q = 1;
         foreach (gains_q[i]) gains_q[i] = GAIN_MAX;
         return;
      end
      zero_q = 0;
      pa = 128'd314159 * amp;
      gains_q[0] = q16_round(128'd240000 * relay_r, pa);
      gains_q[1] = q16_round(128'd480000 * relay_r * rate_r, pa * per);
      gains_q[2] = q16_round(128'd30000 * relay_r * per, pa * rate_r);
   endtask

   // one control tick of the tuner
   task automatic tune_tick(input tick_type t, output tune_rsp_type r);
      int tg, ms, pd, relay;
      tg = t.target;
      ms = t.measured;
      pd = t.pid_drive;
      relay = relay_r;
      if (phase_q != PH_DONE) begin
         for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
         hist[0] = ms;
      end
      case (phase_q)
         PH_INIT: begin
            tick_q = 0;
            foreach (hist[i]) hist[i] = 0;
            trough_t = 0; peak_t = 0; trough_v = 0; peak_v = 0;
            foreach (gains_q[i]) gains_q[i] = 0;
            zero_q = 0;
            phase_q = PH_PREHEAT;
         end
         PH_PREHEAT: begin
            if (ms + margin_r < tg) held_drv = pd;
            else begin
               held_drv = 0;
               phase_q = PH_COAST;
            end
            if (vector_r != 0) begin
               held_drv = 0;
               phase_q = PH_COAST;
            end
         end
         PH_COAST: if (hist[0] < hist[HIST_DEPTH-1]) phase_q = PH_PRESHAKE;
         PH_PRESHAKE: begin
            if (ms < tg) begin
               held_drv = relay;
               marker_q = EDGE_HIGH;
            end else begin
               held_drv = -relay;
               if (marker_q == EDGE_NONE) marker_q = EDGE_LOW;
               else if (marker_q == EDGE_HIGH) begin
                  marker_q = EDGE_NONE;
                  tick_q = 0;
                  phase_q = PH_OSC;
               end
            end
         end
         PH_OSC: begin
            if (tick_q < 65535) tick_q++;
            if (ms < tg) begin
               held_drv = relay;
               if (marker_q == EDGE_NONE) begin
                  marker_q = EDGE_LOW;
                  trough_t = tick_q;
                  trough_v = ms;
               end
               if (marker_q == EDGE_LOW && ms < trough_v) begin
                  trough_t = tick_q;
                  trough_v = ms;
               end
            end else begin
               held_drv = -relay;
               if (marker_q == EDGE_LOW) begin
                  marker_q = EDGE_HIGH;
                  peak_t = tick_q;
                  peak_v = ms;
               end
               if (marker_q == EDGE_HIGH && ms > peak_v) begin
                  peak_t = tick_q;
                  peak_v = ms;
               end
               if (marker_q == EDGE_HIGH && hist[0] < hist[HIST_DEPTH-1]) begin
                  phase_q = PH_ANALYSE;
                  held_drv = 0;
               end
            end
         end
         PH_ANALYSE: begin
            compute_gains();
            phase_q = PH_DONE;
         end
         default: phase_q = PH_DONE;
      endcase
      r.drive    = (phase_q == PH_DONE) ? pd[15:0] : held_drv[15:0];
      r.phase    = phase_q;
      r.done_res = (phase_q == PH_DONE);
      r.zero_amp = (phase_q == PH_DONE) ? zero_q : 1'b0;
      r.gain_p   = (phase_q == PH_DONE) ? gains_q[0] : '0;
      r.gain_i   = (phase_q == PH_DONE) ? gains_q[1] : '0;
      r.gain_d   = (phase_q == PH_DONE) ? gains_q[2] : '0;
   endtask

   // would this tick move the tuner out of preheat, coast, preshake or osc
   function automatic bit leaves_phase(tick_type t);
      int tg, ms;
      tg = t.target;
      ms = t.measured;
      case (phase_q)
         PH_PREHEAT:  return vector_r != 0 || ms + margin_r >= tg;
         PH_COAST:    return ms < hist[HIST_DEPTH-2];
         PH_PRESHAKE: return ms >= tg && marker_q == EDGE_HIGH;
         PH_OSC:      return ms >= tg && marker_q != EDGE_NONE && ms < hist[HIST_DEPTH-2];
         default:     return 0;
      endcase
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic queue_tick(input tick_type t);
      tune_rsp_type r;
      tune_tick(t, r);
      tick_queue.push_back(t);
      tune_rsp_queue.push_back(r);
   endtask

   // random tick that either holds the present phase or is free to leave it
   task automatic queue_random_tick(input bit may_leave);
      tick_type t;
      for (int i = 0; i < 40; i++) begin
         t = {rand_sample(), rand_sample(), rand_sample()};
         if (may_leave || !leaves_phase(t)) break;
      end
      queue_tick(t);
   endtask

   // settings change only once the tuner has nothing in flight
   task automatic wait_idle();
      while (tick_queue.size() != 0 || tune_rsp_queue.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_RELAY:  relay_r  = val & 16'h7FFF;
         REG_RATE:   rate_r   = val;
         REG_VECTOR: vector_r = val & 1;
         REG_MARGIN: margin_r = $signed(val);
         default: ;
      endcase
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_target    <= '0;
         req_measured  <= '0;
         req_pid_drive <= '0;
         req_gap       <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            req_target    <= tick_queue[0].target;
            req_measured  <= tick_queue[0].measured;
            req_pid_drive <= tick_queue[0].pid_drive;
            void'(tick_queue.pop_front());
            req_valid <= 1'b1;
            req_gap   <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      tune_rsp_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_drive, rsp_phase, rsp_done_res, rsp_zero_amplitude,
                   rsp_gain_p, rsp_gain_i, rsp_gain_d};
            if (tune_rsp_queue.size() == 0) begin
               $display("%0t unexpected response %p", $time, got);
               error_count++;
            end else begin
               if (got !== tune_rsp_queue[0]) begin
                  $display("%0t mismatch expected %p actual %p", $time,
                           tune_rsp_queue[0], got);
                  error_count++;
               end
               void'(tune_rsp_queue.pop_front());
            end
         end
         rsp_ready <= (pick_gap() == 0);
      end
   end

   initial begin
      tick_type t;
      int k;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      relay_r = RELAY_RESET; rate_r = RATE_RESET; vector_r = 0; margin_r = 0;
      phase_q = PH_INIT; marker_q = EDGE_NONE;
      foreach (hist[i]) hist[i] = 0;
      tick_q = 0; trough_t = 0; peak_t = 0; trough_v = 0; peak_v = 0;
      foreach (gains_q[i]) gains_q[i] = 0;
      held_drv = 0; zero_q = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: init tick, then field extremes held in preheat by a low margin
      csr_write(REG_MARGIN, 16'h8000);
      csr_write(8'hC8, 16'hFFFF);
      queue_tick('{16'sh0000, 16'sh0000, 16'sh1234});
      queue_tick('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      queue_tick('{16'sh0000, 16'sh7FFF, -16'sh8000});
      queue_tick('{-16'sh0001, -16'sh8000, 16'sh0000});
      queue_tick('{-16'sh8000, -16'sh8000, 16'sh7FFF});
      queue_tick('{16'sh5555, -16'sh5556, -16'sh5556});
      queue_tick('{-16'sh2AAB, 16'sh2AAA, 16'sh2AAA});

      // random ticks in blocks, settings changed between blocks
      k = 0;
      for (int c = 0; c < 11; c++) begin
         wait_idle();
         quiet = (c == 5);
         csr_write(REG_MARGIN, rand_sample());
         case (c)
            0: csr_write(REG_RELAY, 16'h7FFF);
            1: csr_write(REG_RELAY, 16'h0000);
            2: csr_write(REG_VECTOR, 16'hFFFF);
            3: csr_write(REG_VECTOR, 16'h0000);
            4: csr_write(REG_RATE, 16'd1);
            5: csr_write(REG_RATE, 16'hFFFF);
            6: csr_write(REG_RATE, 16'd0);
            default: begin
               csr_write(REG_RELAY, $urandom_range(1, 3) == 1 ? 16'hFFFF : 16'($urandom));
               csr_write(REG_RATE, $urandom_range(1, 3) == 1 ? 16'd1 :
                                   16'($urandom_range(1, 65535)));
            end
         endcase
         for (int i = 0; i < 50; i++) begin
            // coast, preshake and osc are held until k passes a bound; preheat is held throughout
            case (phase_q)
               PH_PREHEAT:  queue_random_tick(0);
               PH_COAST:    queue_random_tick(k >= 170);
               PH_PRESHAKE: queue_random_tick(k >= 240);
               PH_OSC:      queue_random_tick(k >= 420);
               default:     queue_random_tick(1);
            endcase
            k++;
         end
      end

      wait_idle();
      repeat (150) @(posedge clock);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
